/* hw/rtl/assert_macros.svh */
// assertion macros used by the rtl top level of the worst-fit allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/wfba_pkg.sv */
// types and constants shared by the worst-fit allocator modules
`timescale 1ns / 1ps

package wfba_pkg;

    // fixed field widths of the ports
    localparam int COUNT_W    = 6;
    localparam int IDX_OUT_W  = 5;
    localparam int SIZE_OUT_W = 16;

    // item modes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REPORT
    } state_t;

    // control from the sequencer to the fit unit
    typedef struct packed {
        logic clear;
        logic step;
    } fit_ctrl_t;

endpackage

/* hw/rtl/worst_fit_block_allocator.sv */
// worst-fit block allocator top level: sequencer, free flags and result registers
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A load item (mode 0) writes the block size and frees the block when block_index
// is below MAX_BLOCKS, and gives no result. A request item (mode 1) keeps busy
// high through ST_SCAN, ST_DRAIN and ST_REPORT, where ST_SCAN reads L entries and
// L is the smaller of the block count from cfg_data and MAX_BLOCKS; when L is zero
// it goes straight to ST_REPORT. The result strobe done rises at the edge that drops
// busy. It stays high for one cycle, and a new start is taken in that same cycle.
// The size memory's single read port feeds one entry per cycle into the shared compare
// unit; ST_DRAIN lets the last entry through it and ST_REPORT marks the chosen block.
// done cannot be held off: the receiver must take the result in the cycle it is shown.
// Free flags reset at once, so there is no clearing pass after reset.

module worst_fit_block_allocator #(
    parameter int MAX_BLOCKS = 32,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [wfba_pkg::IDX_OUT_W-1:0]      block_index,
    input  logic [wfba_pkg::SIZE_OUT_W-1:0]     item_size,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wfba_pkg::COUNT_W-1:0]        cfg_data,
    output logic                                done,
    output logic                                placed,
    output logic [wfba_pkg::IDX_OUT_W-1:0]      chosen_block,
    output logic [wfba_pkg::SIZE_OUT_W-1:0]     chosen_block_size,
    output logic [wfba_pkg::SIZE_OUT_W-1:0]     leftover
);

    import wfba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // sequencer and datapath registers
    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      count_reg;
    logic [SIZE_WIDTH-1:0]   req_size_reg, req_size_next;
    logic [CNT_W-1:0]        limit_reg, limit_next;
    logic [CNT_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [MAX_BLOCKS-1:0]   taken_reg, taken_next;
    logic                    done_reg, done_next;
    logic                    placed_reg, placed_next;
    logic [IDX_OUT_W-1:0]    chosen_reg, chosen_next;
    logic [SIZE_OUT_W-1:0]   chosen_size_reg, chosen_size_next;
    logic [SIZE_OUT_W-1:0]   leftover_reg, leftover_next;

    // input side decoding
    logic                    accept;
    logic [SIZE_WIDTH+SIZE_OUT_W-1:0] in_size_wide;
    logic [SIZE_WIDTH-1:0]   in_size;
    logic [IDX_W+IDX_OUT_W-1:0] load_addr_wide;
    logic [IDX_W-1:0]        load_addr;
    logic                    load_in_range;
    logic [31:0]             limit_wide;
    logic [CNT_W-1:0]        limit_in;
    logic [CNT_W-1:0]        scan_idx_plus;

    // memory and fit unit connections
    logic                    mem_wr_en;
    logic                    mem_rd_en;
    logic [SIZE_WIDTH-1:0]   mem_rd_data;
    fit_ctrl_t               fit_ctrl;
    logic                    fit_found;
    logic [IDX_W-1:0]        fit_best_idx;
    logic [SIZE_WIDTH-1:0]   fit_best_size;
    logic [SIZE_WIDTH-1:0]   fit_best_rem;

    // result field widening before truncation to port widths
    logic [IDX_W+IDX_OUT_W-1:0]       best_idx_wide;
    logic [SIZE_WIDTH+SIZE_OUT_W-1:0] best_size_wide;
    logic [SIZE_WIDTH+SIZE_OUT_W-1:0] best_rem_wide;

    // handshake and field shaping
    always_comb
    begin
        accept         = start && (state_reg == ST_IDLE);
        in_size_wide   = {{SIZE_WIDTH{1'b0}}, item_size};
        in_size        = in_size_wide[SIZE_WIDTH-1:0];
        load_addr_wide = {{IDX_W{1'b0}}, block_index};
        load_addr      = load_addr_wide[IDX_W-1:0];
        load_in_range  = {{(32-IDX_OUT_W){1'b0}}, block_index} < 32'(MAX_BLOCKS);
        limit_wide     = ({{(32-COUNT_W){1'b0}}, count_reg} > 32'(MAX_BLOCKS)) ?
                         32'(MAX_BLOCKS) : {{(32-COUNT_W){1'b0}}, count_reg};
        limit_in       = limit_wide[CNT_W-1:0];
        scan_idx_plus  = scan_idx_reg + CNT_W'(1);
        best_idx_wide  = {{IDX_OUT_W{1'b0}}, fit_best_idx};
        best_size_wide = {{SIZE_OUT_W{1'b0}}, fit_best_size};
        best_rem_wide  = {{SIZE_OUT_W{1'b0}}, fit_best_rem};
    end

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    // sequencer next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        req_size_next    = req_size_reg;
        limit_next       = limit_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = scan_idx_reg[IDX_W-1:0];
        taken_next       = taken_reg;
        done_next        = 1'b0;
        placed_next      = placed_reg;
        chosen_next      = chosen_reg;
        chosen_size_next = chosen_size_reg;
        leftover_next    = leftover_reg;
        mem_wr_en        = 1'b0;
        mem_rd_en        = 1'b0;
        fit_ctrl.clear   = 1'b0;
        fit_ctrl.step    = cmp_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        if (load_in_range)
                        begin
                            mem_wr_en             = 1'b1;
                            taken_next[load_addr] = 1'b0;
                        end
                    end
                    else
                    begin
                        req_size_next  = in_size;
                        limit_next     = limit_in;
                        scan_idx_next  = '0;
                        fit_ctrl.clear = 1'b1;
                        state_next     = (limit_in == '0) ? ST_REPORT : ST_SCAN;
                    end
                end
            end

            // one entry read per cycle, compared in the next cycle
            ST_SCAN:
            begin
                mem_rd_en      = 1'b1;
                cmp_valid_next = 1'b1;
                scan_idx_next  = scan_idx_plus;
                if (scan_idx_plus == limit_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end

            // last entry goes through the compare unit
            ST_DRAIN:
            begin
                state_next = ST_REPORT;
            end

            // mark the chosen block and load the result
            ST_REPORT:
            begin
                done_next = 1'b1;
                if (fit_found)
                begin
                    taken_next[fit_best_idx] = 1'b1;
                    placed_next      = 1'b1;
                    chosen_next      = best_idx_wide[IDX_OUT_W-1:0];
                    chosen_size_next = best_size_wide[SIZE_OUT_W-1:0];
                    leftover_next    = best_rem_wide[SIZE_OUT_W-1:0];
                end
                else
                begin
                    placed_next      = 1'b0;
                    chosen_next      = '0;
                    chosen_size_next = '0;
                    leftover_next    = '0;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            taken_reg     <= '0;
            done_reg      <= 1'b0;
            scan_idx_reg  <= '0;
            limit_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            taken_reg     <= taken_next;
            done_reg      <= done_next;
            scan_idx_reg  <= scan_idx_next;
            limit_reg     <= limit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_size_reg    <= req_size_next;
        cmp_idx_reg     <= cmp_idx_next;
        placed_reg      <= placed_next;
        chosen_reg      <= chosen_next;
        chosen_size_reg <= chosen_size_next;
        leftover_reg    <= leftover_next;
    end

    // block size store
    wfba_size_mem #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (SIZE_WIDTH),
        .AW    (IDX_W)
    ) u_size_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (load_addr),
        .wr_data (in_size),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    // shared compare unit
    wfba_fit_unit #(
        .SIZE_WIDTH (SIZE_WIDTH),
        .IDX_W      (IDX_W)
    ) u_fit_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (fit_ctrl),
        .req_size   (req_size_reg),
        .entry_size (mem_rd_data),
        .entry_idx  (cmp_idx_reg),
        .entry_free (!taken_reg[cmp_idx_reg]),
        .found      (fit_found),
        .best_idx   (fit_best_idx),
        .best_size  (fit_best_size),
        .best_rem   (fit_best_rem)
    );

    // outputs
    assign busy              = (state_reg != ST_IDLE);
    assign done              = done_reg;
    assign placed            = placed_reg;
    assign chosen_block      = chosen_reg;
    assign chosen_block_size = chosen_size_reg;
    assign leftover          = leftover_reg;

    // checks on the sequencer and free flags
    `ASSERT_IMPLIES(a_scan_in_limit, clk, rst_n, state_reg == ST_SCAN, scan_idx_reg < limit_reg)
    `ASSERT_IMPLIES(a_cmp_only_scanning, clk, rst_n, cmp_valid_reg, (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
    `ASSERT_NEXT(a_request_goes_busy, clk, rst_n, start && !busy && (mode == MODE_REQUEST), busy)
    `ASSERT_NEXT(a_chosen_marked, clk, rst_n, (state_reg == ST_REPORT) && fit_found, taken_reg[fit_best_idx] && done && placed)

endmodule

/* hw/rtl/wfba_size_mem.sv */
// block size memory, one write port and one registered read port
`timescale 1ns / 1ps

module wfba_size_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/wfba_fit_unit.sv */
// shared subtract and compare unit that tracks the worst fit (largest remainder) so far
`timescale 1ns / 1ps

module wfba_fit_unit #(
    parameter int SIZE_WIDTH = 16,
    parameter int IDX_W      = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wfba_pkg::fit_ctrl_t   ctrl,
    input  logic [SIZE_WIDTH-1:0] req_size,
    input  logic [SIZE_WIDTH-1:0] entry_size,
    input  logic [IDX_W-1:0]      entry_idx,
    input  logic                  entry_free,
    output logic                  found,
    output logic [IDX_W-1:0]      best_idx,
    output logic [SIZE_WIDTH-1:0] best_size,
    output logic [SIZE_WIDTH-1:0] best_rem
);

    import wfba_pkg::*;

    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [SIZE_WIDTH-1:0] best_size_reg;
    logic [SIZE_WIDTH-1:0] best_rem_reg;
    logic [SIZE_WIDTH:0]   diff;
    logic                  fits;
    logic                  better;

    // remainder of this entry and whether it beats the best so far
    always_comb
    begin
        diff   = {1'b0, entry_size} - {1'b0, req_size};
        fits   = entry_free && !diff[SIZE_WIDTH];
        better = fits && (!found_reg || (diff[SIZE_WIDTH-1:0] > best_rem_reg));
    end

    // found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.step && better)
        begin
            found_reg <= 1'b1;
        end
    end

    // best candidate payload
    always_ff @(posedge clk)
    begin
        if (ctrl.step && better)
        begin
            best_idx_reg  <= entry_idx;
            best_size_reg <= entry_size;
            best_rem_reg  <= diff[SIZE_WIDTH-1:0];
        end
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_size = best_size_reg;
    assign best_rem  = best_rem_reg;

endmodule
